// ----- rtl/qau_pkg.sv -----
// qau_pkg: shared widths, operation codes and lane decode for the quaternion unit
// no dependencies; imported by qau_mult, qau_lane and quaternion_arith_unit
`timescale 1ns / 1ps

package qau_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int LANES      = 4;
    localparam int PROD_W     = 2 * COMP_WIDTH;
    localparam int ACC_W      = 2 * COMP_WIDTH + 3;
    localparam int LIN_W      = COMP_WIDTH + 1;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [ACC_W-1:0]      acc_t;
    typedef logic signed [LIN_W-1:0]      lin_t;

    typedef enum logic [2:0] {
        OP_MUL   = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_CONJ  = 3'd3,
        OP_CROSS = 3'd4,
        OP_COMM  = 3'd5,
        OP_DOT   = 3'd6
    } op_t;

    typedef struct packed {
        logic [LANES-1:0] use_term;
        logic [LANES-1:0] neg_term;
        logic             dbl;
        logic             rnd;
    } lane_ctl_t;

    localparam acc_t RND_HALF = acc_t'(1) << (FRAC_BITS - 1);
    localparam acc_t COMP_MAX = acc_t'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
    localparam acc_t COMP_MIN = acc_t'(-(64'sd1 <<< (COMP_WIDTH - 1)));

    // term k of lane l is a[k] * b[k ^ l]
    localparam logic [LANES-1:0] NEG_MUL [LANES] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};
    localparam logic [LANES-1:0] USE_CRS [LANES] = '{4'b0000, 4'b1100, 4'b1010, 4'b0110};
    localparam logic [LANES-1:0] USE_DOT = 4'b1110;

    function automatic lane_ctl_t lane_decode(input logic [2:0] cmd, input logic [1:0] lane);
        lane_ctl_t c;
        c = '0;
        case (op_t'(cmd))
            OP_MUL: begin
                c.use_term = '1;
                c.neg_term = NEG_MUL[lane];
                c.rnd      = 1'b1;
            end
            OP_CROSS: begin
                c.use_term = USE_CRS[lane];
                c.neg_term = NEG_MUL[lane] & USE_CRS[lane];
                c.rnd      = 1'b1;
            end
            OP_COMM: begin
                c.use_term = USE_CRS[lane];
                c.neg_term = NEG_MUL[lane] & USE_CRS[lane];
                c.dbl      = 1'b1;
                c.rnd      = 1'b1;
            end
            OP_DOT: begin
                c.use_term = (lane == 2'd0) ? USE_DOT : '0;
                c.rnd      = 1'b1;
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/qau_mult.sv -----
// qau_mult: first pipeline stage, sixteen component products, linear-op values, lane decode
// depends on qau_pkg
`timescale 1ns / 1ps

module qau_mult
    import qau_pkg::*;
(
    input  logic      aclk,
    input  logic      en,
    input  logic [2:0] cmd,
    input  comp_t     a [LANES],
    input  comp_t     b [LANES],
    output prod_t     prod [LANES][LANES],
    output lin_t      lin [LANES],
    output lane_ctl_t ctl [LANES]
);

    prod_t     prod_reg  [LANES][LANES];
    prod_t     prod_next [LANES][LANES];
    lin_t      lin_reg   [LANES];
    lin_t      lin_next  [LANES];
    lane_ctl_t ctl_reg   [LANES];
    lane_ctl_t ctl_next  [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        for (genvar k = 0; k < LANES; k++) begin : g_term
            assign prod_next[l][k] = prod_t'(a[k]) * prod_t'(b[k ^ l]);
        end

        always_comb begin
            case (op_t'(cmd))
                OP_ADD:  lin_next[l] = lin_t'(a[l]) + lin_t'(b[l]);
                OP_SUB:  lin_next[l] = lin_t'(a[l]) - lin_t'(b[l]);
                OP_CONJ: lin_next[l] = (l == 0) ? lin_t'(a[l]) : -lin_t'(a[l]);
                default: lin_next[l] = '0;
            endcase
        end

        assign ctl_next[l] = lane_decode(cmd, 2'(l));

        always_ff @(posedge aclk) begin
            if (en) begin
                prod_reg[l] <= prod_next[l];
                lin_reg[l]  <= lin_next[l];
                ctl_reg[l]  <= ctl_next[l];
            end
        end

        assign prod[l] = prod_reg[l];
        assign lin[l]  = lin_reg[l];
        assign ctl[l]  = ctl_reg[l];
    end

endmodule

// ----- rtl/qau_lane.sv -----
// qau_lane: one result component, signed sum of four products (stage 2), round and clip (stage 3)
// depends on qau_pkg
`timescale 1ns / 1ps

module qau_lane
    import qau_pkg::*;
(
    input  logic      aclk,
    input  logic      en_sum,
    input  logic      en_out,
    input  prod_t     prod [LANES],
    input  lin_t      lin,
    input  lane_ctl_t ctl,
    output comp_t     r,
    output logic      sat
);

    acc_t  acc_reg;
    acc_t  acc_next;
    logic  rnd_reg;
    acc_t  rnd_sum;
    acc_t  rounded;
    comp_t r_reg;
    comp_t r_next;
    logic  sat_reg;
    logic  sat_next;

    // signed sum of the selected terms
    always_comb begin
        acc_next = acc_t'(lin);
        for (int k = 0; k < LANES; k++) begin
            if (ctl.use_term[k]) begin
                if (ctl.neg_term[k]) begin
                    acc_next = acc_next - acc_t'(prod[k]);
                end else begin
                    acc_next = acc_next + acc_t'(prod[k]);
                end
            end
        end
        if (ctl.dbl) begin
            acc_next = acc_next <<< 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_sum) begin
            acc_reg <= acc_next;
            rnd_reg <= ctl.rnd;
        end
    end

    // round half up when rnd is set, then clip
    always_comb begin
        rnd_sum = acc_reg + RND_HALF;
        rounded = rnd_reg ? (rnd_sum >>> FRAC_BITS) : acc_reg;
        if (rounded > COMP_MAX) begin
            r_next   = COMP_MAX[COMP_WIDTH-1:0];
            sat_next = 1'b1;
        end else if (rounded < COMP_MIN) begin
            r_next   = COMP_MIN[COMP_WIDTH-1:0];
            sat_next = 1'b1;
        end else begin
            r_next   = rounded[COMP_WIDTH-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            r_reg   <= r_next;
            sat_reg <= sat_next;
        end
    end

    assign r   = r_reg;
    assign sat = sat_reg;

endmodule

// ----- rtl/quaternion_arith_unit.sv -----
// quaternion_arith_unit: top level, three-stage pipeline of qau_mult and four qau_lane
// depends on qau_pkg, qau_mult, qau_lane
`timescale 1ns / 1ps
//
// usage
//   input word: s_cmd plus quaternions a and b in signed Q3.12, taken when
//   s_valid and s_ready are both high at a rising edge of aclk
//   result word: m_r_w..m_r_z and m_saturated, taken when m_valid and m_ready
//   are both high
//   cmd: mul, add, sub, conjugate of a, cross, commutator, dot (in m_r_w)
//   pipeline: an accepted word passes the multiply, sum and round stages in turn
//   (v1_reg, v2_reg, v3_reg), and m_valid rises when it reaches the round stage
//   throughput: one word per cycle while m_ready stays high, set by the multiply,
//   sum and round stages each holding one word
//   stall: with m_ready low the result holds; earlier stages keep filling
//   empty slots and s_ready drops once all three stages are full
//   reset: aresetn low at a clock edge empties the pipeline; data registers are not reset
//

module quaternion_arith_unit
    import qau_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_cmd,
    input  comp_t      s_a_w,
    input  comp_t      s_a_x,
    input  comp_t      s_a_y,
    input  comp_t      s_a_z,
    input  comp_t      s_b_w,
    input  comp_t      s_b_x,
    input  comp_t      s_b_y,
    input  comp_t      s_b_z,
    output logic       m_valid,
    input  logic       m_ready,
    output comp_t      m_r_w,
    output comp_t      m_r_x,
    output comp_t      m_r_y,
    output comp_t      m_r_z,
    output logic       m_saturated
);

    logic      v1_reg, v2_reg, v3_reg;
    logic      en1, en2, en3;
    comp_t     a [LANES];
    comp_t     b [LANES];
    prod_t     prod [LANES][LANES];
    lin_t      lin [LANES];
    lane_ctl_t ctl [LANES];
    comp_t     r [LANES];
    logic [LANES-1:0] sat;

    assign en3 = !v3_reg || m_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    assign a = '{s_a_w, s_a_x, s_a_y, s_a_z};
    assign b = '{s_b_w, s_b_x, s_b_y, s_b_z};

    qau_mult u_mult (
        .aclk (aclk),
        .en   (en1),
        .cmd  (s_cmd),
        .a    (a),
        .b    (b),
        .prod (prod),
        .lin  (lin),
        .ctl  (ctl)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        qau_lane u_lane (
            .aclk   (aclk),
            .en_sum (en2),
            .en_out (en3),
            .prod   (prod[l]),
            .lin    (lin[l]),
            .ctl    (ctl[l]),
            .r      (r[l]),
            .sat    (sat[l])
        );
    end

    assign s_ready     = en1;
    assign m_valid     = v3_reg;
    assign m_r_w       = r[0];
    assign m_r_x       = r[1];
    assign m_r_y       = r[2];
    assign m_r_z       = r[3];
    assign m_saturated = |sat;

endmodule

// ----- tb/sv/quaternion_arith_unit_test.sv -----
// quaternion_arith_unit_test: self-checking bench for the quaternion unit, directed and random
// words with random sender gaps and receiver stalls, results checked against a predictor here
// depends on qau_pkg and quaternion_arith_unit
`timescale 1ns / 1ps

module quaternion_arith_unit_test;
    import qau_pkg::*;

    localparam int     RANDOM_WORDS = 1950;
    localparam longint COMP_HI      = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
    localparam longint COMP_LO      = -COMP_HI - 1;
    localparam longint HALF_LSB     = longint'(1) <<< (FRAC_BITS - 1);

    localparam int RX_OPEN   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_BURSTY = 2;

    typedef struct packed {
        op_t   cmd;
        comp_t a_w, a_x, a_y, a_z;
        comp_t b_w, b_x, b_y, b_z;
    } quat_word_t;

    typedef struct packed {
        comp_t r_w, r_x, r_y, r_z;
        logic  sat;
    } quat_result_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic       m_ready = 1'b0;
    comp_t      m_r_w, m_r_x, m_r_y, m_r_z;
    logic       m_saturated;
    quat_word_t cur_word = '0;

    quat_word_t   pending_words [$];
    quat_result_t expected_results [$];

    logic word_taken = 1'b0;
    int   burst_left = 1;
    int   gap_left   = 0;
    int   sent_count = 0;
    int   drain_at [2] = '{-1, -1};
    int   rx_mode    = RX_OPEN;
    int   rx_left    = 0;
    int   stall_left = 0;
    int   errors     = 0;

    quaternion_arith_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (cur_word.cmd),
        .s_a_w       (cur_word.a_w),
        .s_a_x       (cur_word.a_x),
        .s_a_y       (cur_word.a_y),
        .s_a_z       (cur_word.a_z),
        .s_b_w       (cur_word.b_w),
        .s_b_x       (cur_word.b_x),
        .s_b_y       (cur_word.b_y),
        .s_b_z       (cur_word.b_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_r_w       (m_r_w),
        .m_r_x       (m_r_x),
        .m_r_y       (m_r_y),
        .m_r_z       (m_r_z),
        .m_saturated (m_saturated)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic quat_result_t quat_op_eval(quat_word_t q);
        longint       aw, ax, ay, az, bw, bx, by, bz;
        longint       s [4];
        logic         shifted;
        logic         sat;
        comp_t        r [4];
        quat_result_t res;
        aw = q.a_w; ax = q.a_x; ay = q.a_y; az = q.a_z;
        bw = q.b_w; bx = q.b_x; by = q.b_y; bz = q.b_z;
        for (int i = 0; i < 4; i++) s[i] = 0;
        shifted = 1'b1;
        sat     = 1'b0;
        case (q.cmd)
            OP_MUL: begin
                s[0] = aw * bw - ax * bx - ay * by - az * bz;
                s[1] = aw * bx + ax * bw + ay * bz - az * by;
                s[2] = aw * by - ax * bz + ay * bw + az * bx;
                s[3] = aw * bz + ax * by - ay * bx + az * bw;
            end
            OP_ADD: begin
                shifted = 1'b0;
                s[0] = aw + bw; s[1] = ax + bx; s[2] = ay + by; s[3] = az + bz;
            end
            OP_SUB: begin
                shifted = 1'b0;
                s[0] = aw - bw; s[1] = ax - bx; s[2] = ay - by; s[3] = az - bz;
            end
            OP_CONJ: begin
                shifted = 1'b0;
                s[0] = aw; s[1] = -ax; s[2] = -ay; s[3] = -az;
            end
            OP_CROSS: begin
                s[1] = ay * bz - az * by;
                s[2] = az * bx - ax * bz;
                s[3] = ax * by - ay * bx;
            end
            OP_COMM: begin
                // doubled before rounding
                s[1] = 2 * (ay * bz - az * by);
                s[2] = 2 * (az * bx - ax * bz);
                s[3] = 2 * (ax * by - ay * bx);
            end
            OP_DOT: begin
                s[0] = ax * bx + ay * by + az * bz;
            end
            default: begin
                shifted = 1'b0;
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            if (shifted) s[i] = (s[i] + HALF_LSB) >>> FRAC_BITS;
            if (s[i] > COMP_HI) begin
                s[i] = COMP_HI;
                sat  = 1'b1;
            end else if (s[i] < COMP_LO) begin
                s[i] = COMP_LO;
                sat  = 1'b1;
            end
            r[i] = comp_t'(s[i]);
        end
        res.r_w = r[0];
        res.r_x = r[1];
        res.r_y = r[2];
        res.r_z = r[3];
        res.sat = sat;
        return res;
    endfunction

    task automatic queue_word(op_t op, comp_t aw, comp_t ax, comp_t ay, comp_t az,
                              comp_t bw, comp_t bx, comp_t by, comp_t bz);
        quat_word_t q;
        q.cmd = op;
        q.a_w = aw; q.a_x = ax; q.a_y = ay; q.a_z = az;
        q.b_w = bw; q.b_x = bx; q.b_y = by; q.b_z = bz;
        pending_words.push_back(q);
    endtask

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 9))
            0:       return comp_t'(-32768);
            1:       return comp_t'(32767);
            2:       return comp_t'(0);
            3, 4, 5: return comp_t'(int'($urandom_range(0, 8192)) - 4096);
            6:       return comp_t'(int'($urandom_range(0, 512)) - 256);
            default: return comp_t'($urandom());
        endcase
    endfunction

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endtask

    // sender: bursts of words with random gaps, one drain pause per marked index
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end else if (s_valid && !word_taken) begin
            // hold until accepted
        end else if (gap_left != 0) begin
            s_valid  <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_words.size() == 0
                     || ((sent_count == drain_at[0] || sent_count == drain_at[1])
                         && expected_results.size() != 0)) begin
            s_valid <= 1'b0;
        end else begin
            cur_word   <= pending_words.pop_front();
            s_valid    <= 1'b1;
            sent_count <= sent_count + 1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 24);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // receiver: phases of open, random and long-stall backpressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_left <= 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(RX_OPEN, RX_BURSTY);
                rx_left <= $urandom_range(20, 300);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN: begin
                    m_ready <= 1'b1;
                end
                RX_RANDOM: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    if (stall_left == 0) begin
                        m_ready    <= ~m_ready;
                        stall_left <= $urandom_range(0, 20);
                    end else begin
                        stall_left <= stall_left - 1;
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin : monitor
        quat_result_t want;
        if (!aresetn) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_valid && s_ready;
            if (s_valid && s_ready) expected_results.push_back(quat_op_eval(cur_word));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: r_w %0d r_x %0d r_y %0d r_z %0d",
                           m_r_w, m_r_x, m_r_y, m_r_z);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("r_w", want.r_w, m_r_w);
                    check_field("r_x", want.r_x, m_r_x);
                    check_field("r_y", want.r_y, m_r_y);
                    check_field("r_z", want.r_z, m_r_z);
                    check_field("saturated", want.sat, m_saturated);
                end
            end
        end
    end

    initial begin
        // every operation on unit-scale values
        queue_word(OP_MUL,   4096, 1024, -2048, 512, 2048, -4096, 300, 4096);
        queue_word(OP_ADD,   4096, 1024, -2048, 512, 2048, -4096, 300, 4096);
        queue_word(OP_SUB,   4096, 1024, -2048, 512, 2048, -4096, 300, 4096);
        queue_word(OP_CONJ,  4096, 1024, -2048, 512, 2048, -4096, 300, 4096);
        queue_word(OP_CROSS, 4096, 1024, -2048, 512, 2048, -4096, 300, 4096);
        queue_word(OP_COMM,  4096, 1024, -2048, 512, 2048, -4096, 300, 4096);
        queue_word(OP_DOT,   4096, 1024, -2048, 512, 2048, -4096, 300, 4096);
        // extremes and saturation
        queue_word(OP_MUL, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        queue_word(OP_MUL, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        queue_word(OP_MUL, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767);
        queue_word(OP_ADD, 32767, -32768, 32767, 0, 32767, -32768, 1, -1);
        queue_word(OP_SUB, -32768, 32767, 0, -1, 32767, -32768, -32768, 32767);
        queue_word(OP_CONJ, -32768, -32768, 32767, 0, 0, 0, 0, 0);
        queue_word(OP_DOT, 0, 32767, 32767, 32767, 0, 32767, 32767, 32767);
        queue_word(OP_DOT, 0, -32768, -32768, -32768, 0, 32767, 32767, 32767);
        queue_word(OP_CROSS, 0, 32767, -32768, 32767, 0, -32768, 32767, -32768);
        queue_word(OP_COMM, 0, 32767, -32768, 32767, 0, -32768, 32767, -32768);
        // rounding ties go toward plus infinity
        queue_word(OP_MUL, 1, 0, 0, 0, 2048, 0, 0, 0);
        queue_word(OP_MUL, -1, 0, 0, 0, 2048, 0, 0, 0);
        queue_word(OP_DOT, 0, 1, 0, 0, 0, -2048, 0, 0);
        // a quarter lsb vanishes in cross; doubled to half an lsb it rounds to one in the commutator
        queue_word(OP_CROSS, 0, 0, 1, 0, 0, 0, 0, 1024);
        queue_word(OP_COMM, 0, 0, 1, 0, 0, 0, 0, 1024);
        queue_word(OP_COMM, 0, 0, -1, 0, 0, 0, 0, 1024);
        queue_word(OP_MUL, 0, 0, 0, 0, 0, 0, 0, 0);
        drain_at[0] = pending_words.size();
        drain_at[1] = drain_at[0] + RANDOM_WORDS / 2;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            queue_word(op_t'($urandom_range(OP_MUL, OP_DOT)),
                       rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                       rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS quaternion_arith_unit");
        end else begin
            $display("FAIL quaternion_arith_unit");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL quaternion_arith_unit");
        $finish;
    end

endmodule
